### rtl/bpc_pkg.sv
package bpc_pkg;

    // default frame size limits
    localparam int MAX_COLUMNS_DEFAULT = 2048;
    localparam int MAX_ROWS_DEFAULT    = 2048;

    // field widths
    localparam int PIX_W    = 8;
    localparam int THR_W    = 8;
    localparam int SIZE_W   = 12;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 12;
    localparam int RES_W    = 15;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 2'd2;

    // register reset values
    localparam logic [THR_W-1:0]  THRESHOLD_RESET    = 8'd80;
    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    // gray conversion, weights in 1/16384
    localparam int GRAY_SUM_W = 22;
    localparam logic [13:0] GRAY_COEF_B = 14'd1868;
    localparam logic [13:0] GRAY_COEF_G = 14'd9617;
    localparam logic [13:0] GRAY_COEF_R = 14'd4899;
    localparam logic [13:0] GRAY_ROUND  = 14'd8192;
    localparam int GRAY_SHIFT = 14;

    // area in 1/256 percent
    localparam int AREA_SCALE   = 25600;
    localparam int AREA_SCALE_W = 15;

    localparam logic [RES_W-1:0] RES_MAX = 15'h7fff;

    // divider operand select
    typedef logic [1:0] bpc_div_sel_t;
    localparam bpc_div_sel_t DIV_SEL_X    = 2'd0;
    localparam bpc_div_sel_t DIV_SEL_Y    = 2'd1;
    localparam bpc_div_sel_t DIV_SEL_AREA = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic         in_ready;
        logic         div_start;
        bpc_div_sel_t div_sel;
        logic         cap_x;
        logic         cap_y;
        logic         cap_area;
        logic         emit;
    } bpc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_pending;
        logic div_done;
        logic out_free;
    } bpc_status_t;

endpackage

### rtl/bright_pixel_centroid.sv
// Bright-pixel centroid. Pixels arrive in raster order, one per clock, and each
// is turned to gray and compared with the threshold register; bright pixels are
// counted and their column and row indices summed. The last pixel of a frame
// (set by frame_width and frame_height, clamped to 1..MAX_COLUMNS/MAX_ROWS)
// produces one output word: centroid x and y in unsigned Q.4, the bright area
// in 1/256 percent, and a found flag on tuser (an empty frame reports the
// frame center and zero area). Inside a frame s_tready stays high and a pixel
// is taken every cycle that s_tvalid is high. After the last pixel of a frame
// the input stalls while one shared restoring divider, one quotient bit per
// cycle, works out x, y and area in turn on a DW-bit dividend (38 bits with
// the default 2048 x 2048 limits), and while the previous word waits to leave
// the output register.
module bright_pixel_centroid #(
    parameter int MAX_COLUMNS = bpc_pkg::MAX_COLUMNS_DEFAULT,
    parameter int MAX_ROWS    = bpc_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration writes
    input  logic                         cfg_we,
    input  logic [bpc_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [bpc_pkg::CFG_DW-1:0]   cfg_wdata,
    // pixel input
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bpc_pkg::S_DATA_W-1:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
    // result output
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bpc_pkg::M_DATA_W-1:0] m_tdata,   // center_x[14:0], center_y[29:15],
                                                    // area_percent[44:30], zero[47:45]
    output logic                         m_tuser    // found
);

    bpc_pkg::bpc_cmd_t    cmd;
    bpc_pkg::bpc_status_t status;

    bpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    bpc_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    assign s_tready = cmd.in_ready;

endmodule

### rtl/bpc_divider.sv
module bpc_divider #(
    parameter int DIVIDEND_W = 38,
    parameter int DIVISOR_W  = 23
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;

    logic [DIVISOR_W:0] rem_shift;
    logic [DIVISOR_W:0] diff;
    logic               ge;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        ge        = rem_shift >= {1'b0, dsr_reg};
        diff      = rem_shift - {1'b0, dsr_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### rtl/bpc_datapath.sv
module bpc_datapath #(
    parameter int MAX_COLUMNS = bpc_pkg::MAX_COLUMNS_DEFAULT,
    parameter int MAX_ROWS    = bpc_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bpc_pkg::bpc_cmd_t             cmd,
    output bpc_pkg::bpc_status_t          status,
    input  logic                          cfg_we,
    input  logic [bpc_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [bpc_pkg::CFG_DW-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    input  logic [bpc_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bpc_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser
);

    localparam int CW   = $clog2(MAX_COLUMNS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int WW   = $clog2(MAX_COLUMNS + 1);
    localparam int HW   = $clog2(MAX_ROWS + 1);
    localparam int NW   = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
    localparam int SXW  = CW + NW;
    localparam int SYW  = RW + NW;
    localparam int ANW  = NW + bpc_pkg::AREA_SCALE_W;
    localparam int DXW  = SXW + 4;
    localparam int DYW  = SYW + 4;
    localparam int DXYW = (DXW > DYW) ? DXW : DYW;
    localparam int DW   = (DXYW > ANW) ? DXYW : ANW;
    localparam int WCW  = (WW > bpc_pkg::SIZE_W) ? WW : bpc_pkg::SIZE_W;
    localparam int HCW  = (HW > bpc_pkg::SIZE_W) ? HW : bpc_pkg::SIZE_W;
    localparam int RES_W = bpc_pkg::RES_W;

    // configuration registers
    logic [bpc_pkg::THR_W-1:0]  thr_reg;
    logic [bpc_pkg::SIZE_W-1:0] fw_reg;
    logic [bpc_pkg::SIZE_W-1:0] fh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= bpc_pkg::THRESHOLD_RESET;
            fw_reg  <= bpc_pkg::FRAME_WIDTH_RESET;
            fh_reg  <= bpc_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                bpc_pkg::REG_THRESHOLD:    thr_reg <= cfg_wdata[bpc_pkg::THR_W-1:0];
                bpc_pkg::REG_FRAME_WIDTH:  fw_reg  <= cfg_wdata;
                bpc_pkg::REG_FRAME_HEIGHT: fh_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp frame size to 1..max
    logic [WCW-1:0] fw_ext;
    logic [HCW-1:0] fh_ext;
    logic [WW-1:0]  w;
    logic [HW-1:0]  h;

    always_comb begin
        fw_ext = WCW'(fw_reg);
        fh_ext = HCW'(fh_reg);
        if (fw_ext == '0) begin
            w = WW'(1);
        end else if (fw_ext > WCW'(MAX_COLUMNS)) begin
            w = WW'(MAX_COLUMNS);
        end else begin
            w = WW'(fw_ext);
        end
        if (fh_ext == '0) begin
            h = HW'(1);
        end else if (fh_ext > HCW'(MAX_ROWS)) begin
            h = HW'(MAX_ROWS);
        end else begin
            h = HW'(fh_ext);
        end
    end

    // gray level and bright test
    logic [bpc_pkg::PIX_W-1:0]      pix_b, pix_g, pix_r;
    logic [bpc_pkg::GRAY_SUM_W-1:0] gray_sum;
    logic [bpc_pkg::PIX_W-1:0]      gray;
    logic                           bright;

    always_comb begin
        pix_b    = s_tdata[7:0];
        pix_g    = s_tdata[15:8];
        pix_r    = s_tdata[23:16];
        gray_sum = bpc_pkg::GRAY_SUM_W'(pix_b) * bpc_pkg::GRAY_SUM_W'(bpc_pkg::GRAY_COEF_B)
                 + bpc_pkg::GRAY_SUM_W'(pix_g) * bpc_pkg::GRAY_SUM_W'(bpc_pkg::GRAY_COEF_G)
                 + bpc_pkg::GRAY_SUM_W'(pix_r) * bpc_pkg::GRAY_SUM_W'(bpc_pkg::GRAY_COEF_R)
                 + bpc_pkg::GRAY_SUM_W'(bpc_pkg::GRAY_ROUND);
        gray     = gray_sum[bpc_pkg::GRAY_SHIFT +: bpc_pkg::PIX_W];
        bright   = gray > thr_reg;
    end

    // raster position
    logic          accept;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          row_end, frame_end;

    assign accept = s_tvalid && cmd.in_ready;

    always_comb begin
        row_end   = WW'(col_reg) >= (w - 1'b1);
        frame_end = row_end && (HW'(row_reg) >= (h - 1'b1));
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept) begin
            if (frame_end) begin
                col_next = '0;
                row_next = '0;
            end else if (row_end) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // pixel stage between test and accumulate
    logic          p_valid_reg;
    logic          p_bright_reg;
    logic          p_last_reg;
    logic [CW-1:0] p_col_reg;
    logic [RW-1:0] p_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            p_valid_reg <= accept;
            p_last_reg  <= accept && frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_bright_reg <= bright;
            p_col_reg    <= col_reg;
            p_row_reg    <= row_reg;
        end
    end

    // bright pixel sums
    logic [SXW-1:0] sum_x_reg;
    logic [SYW-1:0] sum_y_reg;
    logic [NW-1:0]  count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            count_reg <= '0;
        end else if (cmd.emit) begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            count_reg <= '0;
        end else if (p_valid_reg && p_bright_reg) begin
            sum_x_reg <= sum_x_reg + SXW'(p_col_reg);
            sum_y_reg <= sum_y_reg + SYW'(p_row_reg);
            count_reg <= count_reg + 1'b1;
        end
    end

    // area numerator and frame pixel count
    logic [ANW-1:0]   area_num_reg;
    logic [WW+HW-1:0] wh_reg;

    always_ff @(posedge aclk) begin
        area_num_reg <= ANW'(count_reg) * ANW'(bpc_pkg::AREA_SCALE);
        wh_reg       <= (WW + HW)'(w) * (WW + HW)'(h);
    end

    // shared divider
    logic [DW-1:0] div_dividend;
    logic [NW-1:0] div_divisor;
    logic [DW-1:0] div_quotient;
    logic          div_done;

    always_comb begin
        case (cmd.div_sel)
            bpc_pkg::DIV_SEL_X: begin
                div_dividend = DW'({sum_x_reg, 4'b0000});
                div_divisor  = count_reg;
            end
            bpc_pkg::DIV_SEL_Y: begin
                div_dividend = DW'({sum_y_reg, 4'b0000});
                div_divisor  = count_reg;
            end
            default: begin
                div_dividend = DW'(area_num_reg);
                div_divisor  = NW'(wh_reg);
            end
        endcase
    end

    bpc_divider #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (NW)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // saturate a quotient to the result width
    function automatic logic [RES_W-1:0] sat_res(input logic [DW-1:0] q);
        logic [RES_W-1:0] r;
        if (q > DW'(bpc_pkg::RES_MAX)) begin
            r = bpc_pkg::RES_MAX;
        end else begin
            r = q[RES_W-1:0];
        end
        return r;
    endfunction

    logic [RES_W-1:0] qx_reg, qy_reg, qa_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap_x) begin
            qx_reg <= sat_res(div_quotient);
        end
        if (cmd.cap_y) begin
            qy_reg <= sat_res(div_quotient);
        end
        if (cmd.cap_area) begin
            qa_reg <= sat_res(div_quotient);
        end
    end

    // frame center for an empty frame
    logic [31:0] mid_x, mid_y;
    logic        found;

    always_comb begin
        mid_x = 32'(w >> 1) << 4;
        mid_y = 32'(h >> 1) << 4;
        found = count_reg != '0;
    end

    // output register
    logic                         m_valid_reg;
    logic [bpc_pkg::M_DATA_W-1:0] m_data_reg;
    logic                         m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_user_reg <= found;
            if (found) begin
                m_data_reg <= {3'b000, qa_reg, qy_reg, qx_reg};
            end else begin
                m_data_reg <= {3'b000, {RES_W{1'b0}}, mid_y[RES_W-1:0], mid_x[RES_W-1:0]};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        status.last_pending = p_valid_reg && p_last_reg;
        status.div_done     = div_done;
        status.out_free     = !m_valid_reg || m_tready;
    end

endmodule

### rtl/bpc_ctrl.sv
module bpc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bpc_pkg::bpc_status_t status,
    output bpc_pkg::bpc_cmd_t    cmd
);

    localparam logic [2:0] ST_ACCUM   = 3'd0;
    localparam logic [2:0] ST_START_X = 3'd1;
    localparam logic [2:0] ST_WAIT_X  = 3'd2;
    localparam logic [2:0] ST_START_Y = 3'd3;
    localparam logic [2:0] ST_WAIT_Y  = 3'd4;
    localparam logic [2:0] ST_START_A = 3'd5;
    localparam logic [2:0] ST_WAIT_A  = 3'd6;
    localparam logic [2:0] ST_EMIT    = 3'd7;

    logic [2:0] state_reg, state_next;

    // sequence: stream pixels, then three divisions, then hand off the word
    always_comb begin
        state_next    = state_reg;
        cmd.in_ready  = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = bpc_pkg::DIV_SEL_X;
        cmd.cap_x     = 1'b0;
        cmd.cap_y     = 1'b0;
        cmd.cap_area  = 1'b0;
        cmd.emit      = 1'b0;
        case (state_reg)
            ST_ACCUM: begin
                cmd.in_ready = !status.last_pending;
                if (status.last_pending) begin
                    state_next = ST_START_X;
                end
            end
            ST_START_X: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = bpc_pkg::DIV_SEL_X;
                state_next    = ST_WAIT_X;
            end
            ST_WAIT_X: begin
                if (status.div_done) begin
                    cmd.cap_x  = 1'b1;
                    state_next = ST_START_Y;
                end
            end
            ST_START_Y: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = bpc_pkg::DIV_SEL_Y;
                state_next    = ST_WAIT_Y;
            end
            ST_WAIT_Y: begin
                if (status.div_done) begin
                    cmd.cap_y  = 1'b1;
                    state_next = ST_START_A;
                end
            end
            ST_START_A: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = bpc_pkg::DIV_SEL_AREA;
                state_next    = ST_WAIT_A;
            end
            ST_WAIT_A: begin
                if (status.div_done) begin
                    cmd.cap_area = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### tb/bright_pixel_centroid_tb.sv
module bright_pixel_centroid_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COL      = bpc_pkg::MAX_COLUMNS_DEFAULT;
    localparam int MAX_ROW      = bpc_pkg::MAX_ROWS_DEFAULT;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_ITEMS = 450;
    localparam int EDGE_ITEMS   = 100;
    localparam longint TIMEOUT_NS = 10_000_000;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } traffic_mode_t;

    typedef struct packed {
        logic [bpc_pkg::RES_W-1:0] center_x;
        logic [bpc_pkg::RES_W-1:0] center_y;
        logic [bpc_pkg::RES_W-1:0] area_percent;
        logic                      found;
    } centroid_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [bpc_pkg::CFG_AW-1:0]   cfg_addr = '0;
    logic [bpc_pkg::CFG_DW-1:0]   cfg_wdata = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [bpc_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [bpc_pkg::M_DATA_W-1:0] m_tdata;
    logic                         m_tuser;

    bright_pixel_centroid DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // pixels waiting to be sent, centroids waiting to come out
    logic [bpc_pkg::S_DATA_W-1:0] pixel_q[$];
    centroid_t                    centroid_q[$];

    traffic_mode_t idle_mode = IDLE_NONE;
    int err_cnt = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    // shadow registers and accumulators of the predictor
    logic [bpc_pkg::THR_W-1:0]  thr_reg    = bpc_pkg::THRESHOLD_RESET;
    logic [bpc_pkg::SIZE_W-1:0] width_reg  = bpc_pkg::FRAME_WIDTH_RESET;
    logic [bpc_pkg::SIZE_W-1:0] height_reg = bpc_pkg::FRAME_HEIGHT_RESET;
    int unsigned       col_pos = 0;
    int unsigned       row_pos = 0;
    longint unsigned   col_sum = 0;
    longint unsigned   row_sum = 0;
    longint unsigned   bright_cnt = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_error(string msg);
        $display("%0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic int unsigned clamp_dim(logic [bpc_pkg::SIZE_W-1:0] v, int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return 32'(v);
    endfunction

    function automatic logic [bpc_pkg::RES_W-1:0] sat15(longint unsigned v);
        return (v > bpc_pkg::RES_MAX) ? bpc_pkg::RES_MAX : v[bpc_pkg::RES_W-1:0];
    endfunction

    // gray conversion, accumulation, and the centroid at the end of a frame
    function automatic void accumulate_pixel(logic [bpc_pkg::S_DATA_W-1:0] px);
        int unsigned gray;
        int unsigned w;
        int unsigned h;
        logic        row_end;
        logic        frame_end;
        centroid_t   res;
        gray = (32'd1868 * px[7:0] + 32'd9617 * px[15:8] + 32'd4899 * px[23:16]
                + 32'd8192) >> 14;
        w = clamp_dim(width_reg, MAX_COL);
        h = clamp_dim(height_reg, MAX_ROW);
        if (gray > thr_reg) begin
            col_sum += col_pos;
            row_sum += row_pos;
            bright_cnt++;
        end
        row_end = (col_pos >= w - 1);
        frame_end = row_end && (row_pos >= h - 1);
        if (!frame_end) begin
            if (row_end) begin
                col_pos = 0;
                row_pos++;
            end else begin
                col_pos++;
            end
            return;
        end
        // empty frame reports the frame center
        if (bright_cnt == 0) begin
            res.center_x     = bpc_pkg::RES_W'((w >> 1) * 16);
            res.center_y     = bpc_pkg::RES_W'((h >> 1) * 16);
            res.area_percent = '0;
            res.found        = 1'b0;
        end else begin
            res.center_x     = sat15(col_sum * 16 / bright_cnt);
            res.center_y     = sat15(row_sum * 16 / bright_cnt);
            res.area_percent = sat15(bright_cnt * 25600 / (longint'(w) * longint'(h)));
            res.found        = 1'b1;
        end
        centroid_q.push_back(res);
        col_pos = 0;
        row_pos = 0;
        col_sum = 0;
        row_sum = 0;
        bright_cnt = 0;
    endfunction

    function automatic logic idle_roll(traffic_mode_t m, traffic_mode_t side);
        if (m == IDLE_BOTH)
            return $urandom_range(99, 0) < 31;
        if (m == side)
            return $urandom_range(99, 0) < 65;
        return 1'b0;
    endfunction

    // pixel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                accumulate_pixel(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() != 0 && !idle_roll(idle_mode, IDLE_SEND)) begin
                    s_tdata  <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin : result_mon
        centroid_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (centroid_q.size() == 0) begin
                    report_error($sformatf("result word with none expected: %h", m_tdata));
                end else begin
                    want = centroid_q.pop_front();
                    if (m_tdata[14:0] !== want.center_x)
                        report_error($sformatf("center_x got %0d want %0d",
                                               m_tdata[14:0], want.center_x));
                    if (m_tdata[29:15] !== want.center_y)
                        report_error($sformatf("center_y got %0d want %0d",
                                               m_tdata[29:15], want.center_y));
                    if (m_tdata[44:30] !== want.area_percent)
                        report_error($sformatf("area_percent got %0d want %0d",
                                               m_tdata[44:30], want.area_percent));
                    if (m_tdata[47:45] !== 3'b000)
                        report_error($sformatf("pad bits got %b", m_tdata[47:45]));
                    if (m_tuser !== want.found)
                        report_error($sformatf("found got %b want %b", m_tuser, want.found));
                end
            end
            m_tready <= (hold_left == 0) && !idle_roll(idle_mode, IDLE_RECV);
        end
    end

    // one register write, shadow copy follows
    task automatic write_reg(logic [bpc_pkg::CFG_AW-1:0] idx,
                             logic [bpc_pkg::CFG_DW-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            bpc_pkg::REG_THRESHOLD:    thr_reg = val[bpc_pkg::THR_W-1:0];
            bpc_pkg::REG_FRAME_WIDTH:  width_reg = val[bpc_pkg::SIZE_W-1:0];
            bpc_pkg::REG_FRAME_HEIGHT: height_reg = val[bpc_pkg::SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_frame(logic [bpc_pkg::CFG_DW-1:0] thr_word,
                                 logic [bpc_pkg::CFG_DW-1:0] w,
                                 logic [bpc_pkg::CFG_DW-1:0] h);
        write_reg(bpc_pkg::REG_THRESHOLD, thr_word);
        write_reg(bpc_pkg::REG_FRAME_WIDTH, w);
        write_reg(bpc_pkg::REG_FRAME_HEIGHT, h);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // all pixels taken, all centroids out, divider drained
    task automatic wait_idle();
        while (pixel_q.size() != 0 || s_tvalid || centroid_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [bpc_pkg::S_DATA_W-1:0] make_pixel(int style,
                                                                 logic [bpc_pkg::THR_W-1:0] thr);
        int lvl;
        case (style)
            // mostly dark, so some frames come out empty
            1: begin
                if ($urandom_range(99, 0) < 80)
                    return {8'($urandom_range(40, 0)), 8'($urandom_range(40, 0)),
                            8'($urandom_range(40, 0))};
                return 24'($urandom);
            end
            // neutral gray right around the threshold
            2: begin
                lvl = $urandom_range(4, 0);
                lvl = lvl + int'(thr) - 2;
                if (lvl < 0)
                    lvl = 0;
                if (lvl > 255)
                    lvl = 255;
                return {3{8'(lvl)}};
            end
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int total;
        int w;
        int h;
        int cw;
        int ch;
        int frames;
        int n;
        int style;
        int ph;
        logic [bpc_pkg::THR_W-1:0] thr;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // 1x1 frames from zero sizes: every pixel is a frame, each field extreme
        wait_idle();
        program_frame(12'd80, 12'd0, 12'd0);
        idle_mode = IDLE_NONE;
        pixel_q.push_back(24'h000000);
        pixel_q.push_back(24'hffffff);
        pixel_q.push_back(24'h505050);   // gray equal to threshold, not bright
        pixel_q.push_back(24'h515151);   // one above threshold
        pixel_q.push_back(24'h0000ff);
        pixel_q.push_back(24'h00ff00);
        pixel_q.push_back(24'hff0000);

        // threshold zero, 3x2 frame with a truncating area quotient
        wait_idle();
        program_frame(12'd0, 12'd3, 12'd2);
        idle_mode = IDLE_SEND;
        pixel_q.push_back(24'h000000);
        pixel_q.push_back(24'h010101);
        pixel_q.push_back(24'hffffff);
        pixel_q.push_back(24'h000000);
        pixel_q.push_back(24'hff0000);
        pixel_q.push_back(24'h0000ff);

        // threshold at top: nothing is bright, frame center reported
        wait_idle();
        program_frame(12'd255, 12'd2, 12'd1);
        idle_mode = IDLE_RECV;
        pixel_q.push_back(24'hffffff);
        pixel_q.push_back(24'hffffff);

        // size shrinks in the middle of a frame
        wait_idle();
        program_frame(12'd80, 12'd4, 12'd4);
        idle_mode = IDLE_BOTH;
        repeat (2) begin
            pixel_q.push_back(24'hffffff);
            pixel_q.push_back(24'h000000);
        end
        pixel_q.push_back(24'hffffff);
        wait_idle();
        program_frame(12'd80, 12'd2, 12'd2);
        pixel_q.push_back(24'hffffff);

        // receiver holds off while tiny frames keep coming
        wait_idle();
        program_frame(12'd100, 12'd2, 12'd1);
        idle_mode = IDLE_NONE;
        hold_req++;
        repeat (60) pixel_q.push_back(make_pixel(0, 8'd100));

        // random small frames, sometimes ending part way through a frame
        total = 0;
        ph = 0;
        while (total < RANDOM_ITEMS) begin
            w = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(8, 1);
            h = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(6, 1);
            cw = (w == 0) ? 1 : w;
            ch = (h == 0) ? 1 : h;
            case ($urandom_range(5, 0))
                0: thr = 8'd0;
                1: thr = 8'd255;
                default: thr = 8'($urandom);
            endcase
            style = $urandom_range(2, 0);
            frames = $urandom_range(6, 1);
            n = frames * cw * ch;
            if ($urandom_range(3, 0) == 0)
                n += $urandom_range(cw * ch - 1, 0);
            wait_idle();
            program_frame({4'($urandom), thr}, 12'(w), 12'(h));
            idle_mode = traffic_mode_t'(ph % 4);
            if (ph == 9)
                hold_req++;
            repeat (n) pixel_q.push_back(make_pixel(style, thr));
            total += n;
            ph++;
        end

        // long row under an oversize width, then cut short by a narrow width
        wait_idle();
        program_frame({4'($urandom), 8'($urandom)}, 12'd4095, 12'd0);
        idle_mode = IDLE_BOTH;
        repeat (EDGE_ITEMS) pixel_q.push_back(make_pixel(0, thr_reg));
        wait_idle();
        program_frame({4'($urandom), 8'd0}, 12'd3, 12'd0);
        pixel_q.push_back(24'hffffff);

        // long column under an oversize height, then cut short
        wait_idle();
        program_frame({4'($urandom), 8'($urandom)}, 12'd0, 12'd4095);
        idle_mode = IDLE_RECV;
        repeat (EDGE_ITEMS) pixel_q.push_back(make_pixel(0, thr_reg));
        wait_idle();
        program_frame({4'($urandom), 8'd0}, 12'd0, 12'd2);
        pixel_q.push_back(24'hffffff);

        wait_idle();
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
